@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet during rst.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk, quiet during rst.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/lrukv_pkg.sv @@
// Types and constants of the LRU key-value cache.
package lrukv_pkg;

  localparam int ENTRIES_DEF = 16;
  localparam int CAP_W       = 5;
  localparam int KEY_W       = 32;
  localparam int VAL_W       = 32;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Register index, taken from the top address bit.
  localparam logic REG_CAPACITY = 1'b0;

  typedef struct packed {
    logic                    cmd;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic key_eq;
    logic rank_lt;
    logic rank_oldest;
  } cmp_t;

endpackage

@@ rtl/lru_key_value_cache_core.sv @@
// Top level of the fully associative LRU key-value cache.
//
// Requests arrive as words on req (req_valid / req_stall): cmd selects get or
// put, key is matched as a raw 32-bit pattern, value is stored by put. A get
// gives one word on rsp (rsp_valid / rsp_stall): hit, and read_value, which
// is zero on a miss. A put gives no word.
// One request is worked at a time; req_stall stays high until it is done.
// Each pass reads every live entry through the single read port of the
// key/value and rank RAMs and then drains the read pipeline: the first pass
// finds the key and the oldest entry, the second, skipped on a get miss, ages
// the ranks. A get result sits in an output register, so the next request is
// taken while it waits; only a further get result waits on rsp_stall.
// Synchronous reset empties the cache (fill count zero) and sets the capacity
// register to 16; RAM contents need no clearing since live entries are
// exactly slots 0 .. fill count-1. The user must write capacity over the APB
// port at byte address 0 only while idle; the block does not enforce it.
module lru_key_value_cache_core #(
  parameter int ENTRIES = lrukv_pkg::ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  output logic                           req_stall,
  input  lrukv_pkg::req_word_t           req,
  output logic                           rsp_valid,
  input  logic                           rsp_stall,
  output lrukv_pkg::rsp_word_t           rsp,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lrukv_pkg::ADDR_W-1:0]   paddr,
  input  logic [lrukv_pkg::DATA_W-1:0]   pwdata,
  output logic [lrukv_pkg::DATA_W-1:0]   prdata,
  output logic                           pready
);
  import lrukv_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int KV_W  = KEY_W + VAL_W;

  // Registers
  state_t             state;
  state_t             state_next;
  logic [CAP_W-1:0]   capacity;
  logic [OCC_W-1:0]   occ;
  logic [OCC_W-1:0]   rd_cnt;
  logic               pend;
  logic [IDX_W-1:0]   pend_idx;
  req_word_t          req_q;
  logic               found;
  logic [IDX_W-1:0]   hit_idx;
  logic [IDX_W-1:0]   hit_rank;
  logic [VAL_W-1:0]   hit_value;
  logic [IDX_W-1:0]   old_idx;
  logic [IDX_W-1:0]   tgt_idx;
  logic [IDX_W-1:0]   tgt_rank;
  logic               fill;

  // Combinational control
  logic               ren;
  logic               rsp_load;
  logic               out_free;
  logic               full;
  logic [CMP_W-1:0]   cap_ext;
  logic [CMP_W-1:0]   eff_cap;
  logic [IDX_W-1:0]   oldest_rank;
  logic [IDX_W-1:0]   dec_idx;
  logic [IDX_W-1:0]   dec_rank;
  logic               dec_fill;
  logic               kv_we;
  logic [KV_W-1:0]    kv_wdata;
  logic [KV_W-1:0]    kv_rd;
  logic               rk_we;
  logic [IDX_W-1:0]   rk_waddr;
  logic [IDX_W-1:0]   rk_wdata;
  logic [IDX_W-1:0]   rk_rd;
  cmp_t               cmp;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_CAPACITY) ? DATA_W'(capacity) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (psel && penable && pwrite && (paddr[ADDR_W-1] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Clamp capacity to 1 .. ENTRIES and test whether a new key must evict.
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    full = (CMP_W'(occ) >= eff_cap);
  end

  assign oldest_rank = IDX_W'(occ - 1'b1);

  // ---------------------------------------------------------------- storage
  // Issue one entry read per cycle over slots 0 .. occ-1 in either pass.
  assign ren = ((state == ST_SCAN) || (state == ST_UPDATE)) && (rd_cnt != occ);

  assign kv_wdata = {req_q.key, req_q.value};

  lrukv_ram #(
    .WIDTH (KV_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_kv_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (dec_idx),
    .wdata (kv_wdata),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (kv_rd)
  );

  lrukv_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ENTRIES),
    .AW    (IDX_W)
  ) u_rank_ram (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (rk_rd)
  );

  lrukv_cmp #(
    .RANK_W (IDX_W)
  ) u_cmp (
    .key_a    (req_q.key),
    .key_b    (kv_rd[KV_W-1:VAL_W]),
    .rank     (rk_rd),
    .rank_ref (tgt_rank),
    .rank_old (oldest_rank),
    .res      (cmp)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_free = !rsp_valid || !rsp_stall;

  // Choose the slot a put lands in: the match, the oldest, or the next free.
  always_comb begin
    dec_fill = (req_q.cmd == CMD_PUT) && !found && !full;
    if (found) begin
      dec_idx  = hit_idx;
      dec_rank = hit_rank;
    end else if (full) begin
      dec_idx  = old_idx;
      dec_rank = oldest_rank;
    end else begin
      dec_idx  = occ[IDX_W-1:0];
      dec_rank = oldest_rank;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    rsp_load   = 1'b0;
    kv_we      = 1'b0;
    rk_we      = 1'b0;
    rk_waddr   = pend_idx;
    rk_wdata   = rk_rd + 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if ((rd_cnt == occ) && !pend) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (req_q.cmd == CMD_GET) begin
          // Hold until the output register can take the word.
          if (out_free) begin
            rsp_load   = 1'b1;
            state_next = found ? ST_UPDATE : ST_IDLE;
          end
        end else begin
          kv_we      = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // Age every live entry younger than the target; a fill ages them all.
        if (pend && (pend_idx != tgt_idx) && (fill || cmp.rank_lt)) begin
          rk_we = 1'b1;
        end
        if ((rd_cnt == occ) && !pend) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        rk_we      = 1'b1;
        rk_waddr   = tgt_idx;
        rk_wdata   = '0;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      occ       <= '0;
      rd_cnt    <= '0;
      pend      <= 1'b0;
      found     <= 1'b0;
      fill      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      pend     <= ren;
      pend_idx <= rd_cnt[IDX_W-1:0];
      if (ren) begin
        rd_cnt <= rd_cnt + 1'b1;
      end

      if ((state == ST_IDLE) && req_valid) begin
        req_q  <= req;
        found  <= 1'b0;
        rd_cnt <= '0;
      end

      if ((state == ST_SCAN) && pend) begin
        if (cmp.key_eq) begin
          found     <= 1'b1;
          hit_idx   <= pend_idx;
          hit_rank  <= rk_rd;
          hit_value <= kv_rd[VAL_W-1:0];
        end
        if (cmp.rank_oldest) begin
          old_idx <= pend_idx;
        end
      end

      if (state == ST_DECIDE) begin
        tgt_idx  <= dec_idx;
        tgt_rank <= dec_rank;
        fill     <= dec_fill;
        rd_cnt   <= '0;
      end

      if ((state == ST_FINISH) && fill) begin
        occ <= occ + 1'b1;
      end

      // Output register: load a get result, drop it once taken.
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.hit        <= found;
      rsp.read_value <= found ? hit_value : '0;
    end
  end

endmodule

@@ rtl/lrukv_ram.sv @@
// Simple dual-port RAM with one write port and one registered read port.
module lrukv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lrukv_cmp.sv @@
// Shared compare unit: key match and rank compares for one entry per cycle.
module lrukv_cmp #(
  parameter int RANK_W = 4
) (
  input  logic [lrukv_pkg::KEY_W-1:0] key_a,
  input  logic [lrukv_pkg::KEY_W-1:0] key_b,
  input  logic [RANK_W-1:0]           rank,
  input  logic [RANK_W-1:0]           rank_ref,
  input  logic [RANK_W-1:0]           rank_old,
  output lrukv_pkg::cmp_t             res
);
  import lrukv_pkg::*;

  always_comb begin
    res.key_eq      = (key_a == key_b);
    res.rank_lt     = (rank < rank_ref);
    res.rank_oldest = (rank == rank_old);
  end

endmodule

@@ rtl/lrukv_checker.sv @@
// Port-level checks of the LRU key-value cache, bound to its top level.
`include "assert_macros.svh"

module lrukv_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input lrukv_pkg::req_word_t req,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input lrukv_pkg::rsp_word_t rsp,
  input logic                 pready
);
  import lrukv_pkg::*;

  // A stalled result word holds.
  `ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  // An accepted request keeps the block busy in the following cycle.
  `ASSERT_NXT(a_busy_after_accept, req_valid && !req_stall, req_stall)
  // A miss carries a zero value.
  `ASSERT_IMP(a_miss_zero, rsp_valid && !rsp.hit, rsp.read_value == '0)
  // A new result only comes out of a request in progress.
  `ASSERT_IMP(a_rsp_from_work, $rose(rsp_valid), $past(req_stall))
  `ASSERT_IMP(a_pready_high, 1'b1, pready)

endmodule

bind lru_key_value_cache_core lrukv_checker u_lrukv_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp),
  .pready    (pready)
);
